### sv/tpc_pkg.sv
// tpc_pkg: shared widths, word types and datapath commands for the plane clipper
// no dependencies; used by tpc_ctrl, tpc_datapath and triangle_plane_clipper
package tpc_pkg;

    localparam int CW = 32;              // coordinate width
    localparam int FB = 16;              // fraction bits
    localparam int MW = CW + 1;          // multiplier operand width
    localparam int PW = 2 * MW;          // product width
    localparam int AW = PW + 2;          // accumulator width
    localparam int QW = FB + 1;          // crossing ratio width
    localparam int SW = $clog2(FB);      // divider step counter width

    typedef struct packed {
        logic [1:0]           corner_index;
        logic signed [CW-1:0] pos_x;
        logic signed [CW-1:0] pos_y;
        logic signed [CW-1:0] pos_z;
        logic signed [CW-1:0] tex_u;
        logic signed [CW-1:0] tex_v;
        logic [63:0]          face_attr;
    } in_word_t;

    typedef struct packed {
        logic signed [CW-1:0] out_x;
        logic signed [CW-1:0] out_y;
        logic signed [CW-1:0] out_z;
        logic signed [CW-1:0] out_u;
        logic signed [CW-1:0] out_v;
        logic [63:0]          out_attr;
        logic [1:0]           out_corner;
        logic                 run_last;
    } out_word_t;

    // datapath operations
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_LD0      = 4'd1;
    localparam logic [3:0] OP_LD1      = 4'd2;
    localparam logic [3:0] OP_LD2      = 4'd3;
    localparam logic [3:0] OP_MUL_D    = 4'd4;
    localparam logic [3:0] OP_ACC_D    = 4'd5;
    localparam logic [3:0] OP_FIN_D    = 4'd6;
    localparam logic [3:0] OP_PUSH_V   = 4'd7;
    localparam logic [3:0] OP_DIV_INIT = 4'd8;
    localparam logic [3:0] OP_DIV_STEP = 4'd9;
    localparam logic [3:0] OP_MUL_I    = 4'd10;
    localparam logic [3:0] OP_ADD_I    = 4'd11;
    localparam logic [3:0] OP_EMIT     = 4'd12;

    // corner codes on the input word
    localparam logic [1:0] CORNER_0 = 2'd0;
    localparam logic [1:0] CORNER_1 = 2'd1;
    localparam logic [1:0] CORNER_2 = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_NX  = 2'd0;
    localparam logic [1:0] CFG_NY  = 2'd1;
    localparam logic [1:0] CFG_NZ  = 2'd2;
    localparam logic [1:0] CFG_OFS = 2'd3;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] vi;     // first vertex of the edge
        logic [1:0] vj;     // second vertex of the edge
        logic [2:0] ci;     // component
        logic [2:0] ei;     // emit slot
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] ins;    // corner inside the plane
        logic [2:0] npoly;  // polygon vertex count
    } dp_stat_t;

    // polygon entry for emit slot e; a quad is sent as two fanned triangles
    function automatic logic [1:0] emit_src(input logic quad, input logic [2:0] e);
        logic [1:0] s;
        s = e[1:0];
        if (quad)
        begin
            case (e)
                3'd3:    s = 2'd0;
                3'd4:    s = 2'd2;
                3'd5:    s = 2'd3;
                default: s = e[1:0];
            endcase
        end
        return s;
    endfunction

    function automatic logic [1:0] emit_corner(input logic quad, input logic [2:0] e);
        logic [2:0] c;
        c = (quad && e >= 3'd3) ? e - 3'd3 : e;
        return c[1:0];
    endfunction

    function automatic logic emit_last(input logic quad, input logic [2:0] e);
        return quad ? (e == 3'd5) : (e == 3'd2);
    endfunction

endpackage

### sv/tpc_datapath.sv
// tpc_datapath: plane registers, corner store, shared multiplier, divider and output word
// depends on tpc_pkg; driven by commands from tpc_ctrl
module tpc_datapath
    import tpc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [CW-1:0] cfg_data,
    input  in_word_t      in_word,
    input  dp_cmd_t       cmd,
    output dp_stat_t      stat,
    output out_word_t     out_word
);

    localparam logic signed [AW-1:0] SMAX = {{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [AW-1:0] SMIN = {{(AW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    function automatic logic signed [CW-1:0] sat(input logic signed [AW-1:0] t);
        logic signed [CW-1:0] r;
        if (t > SMAX)
            r = SMAX[CW-1:0];
        else if (t < SMIN)
            r = SMIN[CW-1:0];
        else
            r = t[CW-1:0];
        return r;
    endfunction

    logic signed [CW-1:0] nx_reg, ny_reg, nz_reg, ofs_reg;
    logic signed [CW-1:0] vert_reg [3][5];
    logic signed [CW-1:0] poly_reg [4][5];
    logic signed [CW-1:0] dist_reg [3];
    logic [63:0]          attr_reg;
    logic [2:0]           npoly_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] acc_reg;
    logic [MW-1:0]        den_reg, rem_reg;
    logic [QW-1:0]        q_reg;
    out_word_t            out_reg;

    logic signed [CW-1:0] in_comp [5];
    logic signed [CW-1:0] nrm_sel, va, vb;
    logic signed [MW-1:0] mul_a, mul_b, da, dd;
    logic [MW-1:0]        num, den;
    logic [MW:0]          rem2;
    logic signed [AW-1:0] dsum, isum;
    logic [1:0]           src;
    logic                 quad;

    // operand selection
    always_comb
    begin
        in_comp[0] = in_word.pos_x;
        in_comp[1] = in_word.pos_y;
        in_comp[2] = in_word.pos_z;
        in_comp[3] = in_word.tex_u;
        in_comp[4] = in_word.tex_v;
        case (cmd.ci)
            3'd0:    nrm_sel = nx_reg;
            3'd1:    nrm_sel = ny_reg;
            default: nrm_sel = nz_reg;
        endcase
        va = vert_reg[cmd.vi][cmd.ci];
        vb = vert_reg[cmd.vj][cmd.ci];
        if (cmd.op == OP_MUL_D)
        begin
            mul_a = MW'(nrm_sel);
            mul_b = MW'(va);
        end
        else
        begin
            mul_a = MW'(vb) - MW'(va);
            mul_b = $signed({{(MW-QW){1'b0}}, q_reg});
        end
    end

    // division set-up and distance / interpolation sums
    always_comb
    begin
        da   = MW'(dist_reg[cmd.vi]);
        dd   = da - MW'(dist_reg[cmd.vj]);
        num  = da[MW-1] ? MW'(-da) : MW'(da);
        den  = dd[MW-1] ? MW'(-dd) : MW'(dd);
        rem2 = {rem_reg, 1'b0};
        dsum = (acc_reg >>> FB) + AW'(ofs_reg);
        isum = AW'(prod_reg >>> FB) + AW'(va);
        quad = (npoly_reg == 3'd4);
        src  = emit_src(quad, cmd.ei);
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg  <= '0;
            ny_reg  <= '0;
            nz_reg  <= CW'(1) << FB;
            ofs_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NX:  nx_reg  <= cfg_data;
                CFG_NY:  ny_reg  <= cfg_data;
                CFG_NZ:  nz_reg  <= cfg_data;
                CFG_OFS: ofs_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // polygon count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            npoly_reg <= '0;
        else if (cmd.op == OP_LD2)
            npoly_reg <= '0;
        else if (cmd.op == OP_PUSH_V || (cmd.op == OP_ADD_I && cmd.ci == 3'd4))
            npoly_reg <= npoly_reg + 3'd1;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LD0:
            begin
                for (int k = 0; k < 5; k++)
                    vert_reg[0][k] <= in_comp[k];
                attr_reg <= in_word.face_attr;
            end
            OP_LD1:
                for (int k = 0; k < 5; k++)
                    vert_reg[1][k] <= in_comp[k];
            OP_LD2:
                for (int k = 0; k < 5; k++)
                    vert_reg[2][k] <= in_comp[k];
            OP_MUL_D, OP_MUL_I:
                prod_reg <= mul_a * mul_b;
            OP_ACC_D:
                acc_reg <= ((cmd.ci == 3'd0) ? '0 : acc_reg) + AW'(prod_reg);
            OP_FIN_D:
                dist_reg[cmd.vi] <= sat(dsum);
            OP_PUSH_V:
                for (int k = 0; k < 5; k++)
                    poly_reg[npoly_reg[1:0]][k] <= vert_reg[cmd.vi][k];
            OP_DIV_INIT:
            begin
                den_reg <= den;
                if (num >= den)
                begin
                    q_reg   <= QW'(1);
                    rem_reg <= num - den;
                end
                else
                begin
                    q_reg   <= '0;
                    rem_reg <= num;
                end
            end
            OP_DIV_STEP:
            begin
                if (rem2 >= {1'b0, den_reg})
                begin
                    rem_reg <= MW'(rem2 - {1'b0, den_reg});
                    q_reg   <= {q_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem2[MW-1:0];
                    q_reg   <= {q_reg[QW-2:0], 1'b0};
                end
            end
            OP_ADD_I:
                poly_reg[npoly_reg[1:0]][cmd.ci] <= sat(isum);
            OP_EMIT:
            begin
                out_reg.out_x      <= poly_reg[src][0];
                out_reg.out_y      <= poly_reg[src][1];
                out_reg.out_z      <= poly_reg[src][2];
                out_reg.out_u      <= poly_reg[src][3];
                out_reg.out_v      <= poly_reg[src][4];
                out_reg.out_attr   <= attr_reg;
                out_reg.out_corner <= emit_corner(quad, cmd.ei);
                out_reg.run_last   <= emit_last(quad, cmd.ei);
            end
            default: ;
        endcase
    end

    assign stat.ins   = {~dist_reg[2][CW-1], ~dist_reg[1][CW-1], ~dist_reg[0][CW-1]};
    assign stat.npoly = npoly_reg;
    assign out_word   = out_reg;

endmodule

### sv/tpc_ctrl.sv
// tpc_ctrl: sequencer for corner capture, plane distances, crossings and emission
// depends on tpc_pkg; commands tpc_datapath
module tpc_ctrl
    import tpc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic [1:0] in_corner,
    input  logic     out_stall,
    input  dp_stat_t stat,
    output logic     in_stall,
    output logic     out_valid,
    output dp_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DMUL  = 4'd1;
    localparam logic [3:0] S_DACC  = 4'd2;
    localparam logic [3:0] S_DFIN  = 4'd3;
    localparam logic [3:0] S_PICK  = 4'd4;
    localparam logic [3:0] S_DINIT = 4'd5;
    localparam logic [3:0] S_DSTEP = 4'd6;
    localparam logic [3:0] S_IMUL  = 4'd7;
    localparam logic [3:0] S_IADD  = 4'd8;
    localparam logic [3:0] S_CHKN  = 4'd9;
    localparam logic [3:0] S_EMIT  = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [1:0]    held_reg, held_next;
    logic [1:0]    vi_reg, vi_next;
    logic [2:0]    ci_reg, ci_next;
    logic [2:0]    ei_reg, ei_next;
    logic [SW-1:0] step_reg, step_next;
    logic          ov_reg, ov_next;
    logic [1:0]    vj;
    logic          load;
    logic          quad;

    assign vj   = (vi_reg == 2'd2) ? 2'd0 : vi_reg + 2'd1;
    assign quad = (stat.npoly == 3'd4);
    assign load = !ov_reg || !out_stall;

    // next state and command
    always_comb
    begin
        state_next = state_reg;
        held_next  = held_reg;
        vi_next    = vi_reg;
        ci_next    = ci_reg;
        ei_next    = ei_reg;
        step_next  = step_reg;
        ov_next    = out_stall ? ov_reg : 1'b0;
        cmd.op     = OP_NONE;
        cmd.vi     = vi_reg;
        cmd.vj     = vj;
        cmd.ci     = ci_reg;
        cmd.ei     = ei_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    case (in_corner)
                        CORNER_0:
                        begin
                            cmd.op    = OP_LD0;
                            held_next = 2'd1;
                        end
                        CORNER_1:
                            if (held_reg == 2'd1)
                            begin
                                cmd.op    = OP_LD1;
                                held_next = 2'd2;
                            end
                            else
                                held_next = 2'd0;
                        CORNER_2:
                        begin
                            held_next = 2'd0;
                            if (held_reg == 2'd2)
                            begin
                                cmd.op     = OP_LD2;
                                vi_next    = 2'd0;
                                ci_next    = 3'd0;
                                state_next = S_DMUL;
                            end
                        end
                        default: ;
                    endcase
                end
            S_DMUL:
            begin
                cmd.op     = OP_MUL_D;
                state_next = S_DACC;
            end
            S_DACC:
            begin
                cmd.op = OP_ACC_D;
                if (ci_reg == 3'd2)
                    state_next = S_DFIN;
                else
                begin
                    ci_next    = ci_reg + 3'd1;
                    state_next = S_DMUL;
                end
            end
            S_DFIN:
            begin
                cmd.op  = OP_FIN_D;
                ci_next = 3'd0;
                if (vi_reg == 2'd2)
                begin
                    vi_next    = 2'd0;
                    state_next = S_PICK;
                end
                else
                begin
                    vi_next    = vi_reg + 2'd1;
                    state_next = S_DMUL;
                end
            end
            S_PICK:
            begin
                if (stat.ins[vi_reg])
                    cmd.op = OP_PUSH_V;
                if (stat.ins[vi_reg] != stat.ins[vj])
                    state_next = S_DINIT;
                else if (vi_reg == 2'd2)
                    state_next = S_CHKN;
                else
                    vi_next = vi_reg + 2'd1;
            end
            S_DINIT:
            begin
                cmd.op     = OP_DIV_INIT;
                step_next  = '0;
                state_next = S_DSTEP;
            end
            S_DSTEP:
            begin
                cmd.op    = OP_DIV_STEP;
                step_next = step_reg + SW'(1);
                if (step_reg == SW'(FB - 1))
                begin
                    ci_next    = 3'd0;
                    state_next = S_IMUL;
                end
            end
            S_IMUL:
            begin
                cmd.op     = OP_MUL_I;
                state_next = S_IADD;
            end
            S_IADD:
            begin
                cmd.op = OP_ADD_I;
                if (ci_reg == 3'd4)
                begin
                    ci_next = 3'd0;
                    if (vi_reg == 2'd2)
                        state_next = S_CHKN;
                    else
                    begin
                        vi_next    = vi_reg + 2'd1;
                        state_next = S_PICK;
                    end
                end
                else
                begin
                    ci_next    = ci_reg + 3'd1;
                    state_next = S_IMUL;
                end
            end
            S_CHKN:
            begin
                ei_next    = 3'd0;
                state_next = (stat.npoly == 3'd0) ? S_IDLE : S_EMIT;
            end
            S_EMIT:
                if (load)
                begin
                    cmd.op  = OP_EMIT;
                    ov_next = 1'b1;
                    ei_next = ei_reg + 3'd1;
                    if (emit_last(quad, ei_reg))
                        state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            held_reg  <= '0;
            vi_reg    <= '0;
            ci_reg    <= '0;
            ei_reg    <= '0;
            step_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            vi_reg    <= vi_next;
            ci_reg    <= ci_next;
            ei_reg    <= ei_next;
            step_reg  <= step_next;
            ov_reg    <= ov_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;

endmodule

### sv/triangle_plane_clipper.sv
// triangle_plane_clipper: clips a triangle stream against one configured plane
// depends on tpc_pkg, tpc_ctrl and tpc_datapath
//
//   word     direction  handshake              payload
//   in       input      in_valid / in_stall    in_word_t, one vertex
//   out      output     out_valid / out_stall  out_word_t, one emitted vertex
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// corners 0 and 1 are each loaded while idle; corner 2 starts the distance
// work (three dot products on the one shared multiplier), then a decision
// state per corner, per crossing a divider set-up, 16 divider steps and five
// multiply-add pairs, a check state, then one emitted vertex per cycle
// unless out_stall holds the output register.
// in_stall is high from corner 2 until its last vertex is loaded for output, or until the check finds none to emit.
// reset clears control state and loads the plane registers with their defaults.
module triangle_plane_clipper
    import tpc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  in_word_t      in_word,
    output logic          out_valid,
    input  logic          out_stall,
    output out_word_t     out_word,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [CW-1:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    tpc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_corner (in_word.corner_index),
        .out_stall (out_stall),
        .stat      (stat),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // arithmetic and storage
    tpc_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_word),
        .cmd       (cmd),
        .stat      (stat),
        .out_word  (out_word)
    );

endmodule

### bench/triangle_plane_clipper_test.sv
// triangle_plane_clipper_test: self-checking bench for the triangle plane clipper
// depends on tpc_pkg and triangle_plane_clipper; predicts emitted vertices per triangle
`timescale 1ns / 1ps

module triangle_plane_clipper_test;
    import tpc_pkg::*;

    typedef struct {
        logic signed [63:0] c [5];
    } vtx_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_word_t  in_word;
    logic      out_valid;
    logic      out_stall;
    out_word_t out_word;
    logic      cfg_we;
    logic [1:0] cfg_index;
    logic [CW-1:0] cfg_data;

    triangle_plane_clipper u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // plane and held corners of the predictor
    logic signed [63:0] pl_n [3];
    logic signed [63:0] pl_ofs;
    vtx_t    held0, held1;
    logic [63:0] held_attr;
    int      held_cnt;

    in_word_t  vertex_queue [$];
    out_word_t clipped_queue [$];
    int  errors;
    longint cycles;
    logic feed_on;

    // saturate to the coordinate range
    function automatic logic signed [63:0] clamp(input logic signed [127:0] a);
        if (a > 128'sd2147483647)
            return 64'sd2147483647;
        if (a < -128'sd2147483648)
            return -64'sd2147483648;
        return a[63:0];
    endfunction

    function automatic logic signed [63:0] plane_dist(input vtx_t v);
        logic signed [127:0] s;
        s = 0;
        for (int k = 0; k < 3; k++)
            s += 128'(pl_n[k]) * 128'(v.c[k]);
        s = s >>> FB;
        return clamp(s + 128'(pl_ofs));
    endfunction

    function automatic vtx_t cross_edge(input vtx_t a, input vtx_t b,
                                        input logic signed [63:0] da,
                                        input logic signed [63:0] db);
        logic [127:0] num, den, q;
        logic signed [127:0] p;
        vtx_t o;
        num = da < 0 ? 128'(-da) : 128'(da);
        den = (da - db) < 0 ? 128'(db - da) : 128'(da - db);
        if (den == 0)
            den = 1;
        q = (num << FB) / den;
        for (int k = 0; k < 5; k++)
        begin
            p = (128'(b.c[k] - a.c[k]) * $signed(q)) >>> FB;
            o.c[k] = clamp(p + 128'(a.c[k]));
        end
        return o;
    endfunction

    function automatic out_word_t make_out(input vtx_t v, input int corner,
                                           input logic last);
        out_word_t w;
        w.out_x = v.c[0][CW-1:0];
        w.out_y = v.c[1][CW-1:0];
        w.out_z = v.c[2][CW-1:0];
        w.out_u = v.c[3][CW-1:0];
        w.out_v = v.c[4][CW-1:0];
        w.out_attr = held_attr;
        w.out_corner = corner[1:0];
        w.run_last = last;
        return w;
    endfunction

    function automatic vtx_t word_vtx(input in_word_t w);
        vtx_t v;
        v.c[0] = w.pos_x;
        v.c[1] = w.pos_y;
        v.c[2] = w.pos_z;
        v.c[3] = w.tex_u;
        v.c[4] = w.tex_v;
        return v;
    endfunction

    // predict the emitted vertices for one accepted word
    task automatic clip_predict(input in_word_t w);
        vtx_t v [3];
        vtx_t poly [4];
        logic signed [63:0] d [3];
        logic ins [3];
        int n;
        int j;
        n = 0;
        if (w.corner_index == CORNER_0)
        begin
            held0 = word_vtx(w);
            held_attr = w.face_attr;
            held_cnt = 1;
        end
        else if (w.corner_index == CORNER_1)
        begin
            if (held_cnt == 1)
            begin
                held1 = word_vtx(w);
                held_cnt = 2;
            end
            else
                held_cnt = 0;
        end
        else if (w.corner_index == CORNER_2)
        begin
            if (held_cnt == 2)
            begin
                v[0] = held0;
                v[1] = held1;
                v[2] = word_vtx(w);
                for (int i = 0; i < 3; i++)
                begin
                    d[i] = plane_dist(v[i]);
                    ins[i] = d[i] >= 0;
                end
                for (int i = 0; i < 3; i++)
                begin
                    j = (i + 1) % 3;
                    if (ins[i] && n < 4)
                    begin
                        poly[n] = v[i];
                        n++;
                    end
                    if (ins[i] != ins[j] && n < 4)
                    begin
                        poly[n] = cross_edge(v[i], v[j], d[i], d[j]);
                        n++;
                    end
                end
                if (n == 3)
                    for (int i = 0; i < 3; i++)
                        clipped_queue.push_back(make_out(poly[i], i, i == 2));
                else if (n == 4)
                begin
                    clipped_queue.push_back(make_out(poly[0], 0, 1'b0));
                    clipped_queue.push_back(make_out(poly[1], 1, 1'b0));
                    clipped_queue.push_back(make_out(poly[2], 2, 1'b0));
                    clipped_queue.push_back(make_out(poly[0], 0, 1'b0));
                    clipped_queue.push_back(make_out(poly[2], 1, 1'b0));
                    clipped_queue.push_back(make_out(poly[3], 2, 1'b1));
                end
            end
            held_cnt = 0;
        end
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 99) < 50)
            return 0;
        if ($urandom_range(0, 99) < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // driver: one word from the queue at a time, with random gaps
    int in_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                clip_predict(in_word);
            if (in_valid && in_stall)
                ;
            else if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (feed_on && vertex_queue.size() > 0)
            begin
                in_word <= vertex_queue.pop_front();
                in_valid <= 1'b1;
                in_gap <= gap_len();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor: compare each emitted vertex with the oldest prediction
    int out_gap;
    out_word_t exp_w;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (clipped_queue.size() == 0)
                begin
                    $display("%0t: unexpected word %p", $time, out_word);
                    errors++;
                end
                else
                begin
                    exp_w = clipped_queue.pop_front();
                    if (exp_w !== out_word)
                    begin
                        $display("%0t: mismatch expected %p actual %p",
                                 $time, exp_w, out_word);
                        errors++;
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_stall <= 1'b1;
                out_gap <= out_gap - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                out_gap <= gap_len();
            end
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 2000000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 65535) - 32768;
            default: return ($urandom_range(0, 1) ? 32'd0 : 32'hffffffff) ^
                            ($urandom >> $urandom_range(0, 20));
        endcase
    endfunction

    function automatic in_word_t rand_vertex(input logic [1:0] corner);
        in_word_t w;
        w.corner_index = corner;
        w.pos_x = rand_coord();
        w.pos_y = rand_coord();
        w.pos_z = rand_coord();
        w.tex_u = $urandom;
        w.tex_v = $urandom;
        w.face_attr = {$urandom, $urandom};
        return w;
    endfunction

    function automatic in_word_t fixed_vertex(input logic [1:0] corner,
                                              input logic [CW-1:0] z);
        in_word_t w;
        w = rand_vertex(corner);
        w.pos_z = z;
        return w;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [CW-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        pl_n[0] = (idx == CFG_NX) ? 64'($signed(val)) : pl_n[0];
        pl_n[1] = (idx == CFG_NY) ? 64'($signed(val)) : pl_n[1];
        pl_n[2] = (idx == CFG_NZ) ? 64'($signed(val)) : pl_n[2];
        pl_ofs  = (idx == CFG_OFS) ? 64'($signed(val)) : pl_ofs;
    endtask

    // run queued words to completion, then let the block settle
    task automatic drain();
        feed_on = 1'b1;
        wait (vertex_queue.size() == 0);
        @(posedge clk);
        while (in_valid || clipped_queue.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic push_random(input int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 88)
            begin
                vertex_queue.push_back(rand_vertex(CORNER_0));
                vertex_queue.push_back(rand_vertex(CORNER_1));
                vertex_queue.push_back(rand_vertex(CORNER_2));
                i += 2;
            end
            else
                vertex_queue.push_back(rand_vertex(2'($urandom_range(0, 3))));
        end
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        feed_on = 1'b0;
        held_cnt = 0;
        pl_n[0] = 0;
        pl_n[1] = 0;
        pl_n[2] = 65536;
        pl_ofs = 0;
        in_word = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_NX;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset plane z >= 0, all in, all out, one and two in
        vertex_queue.push_back(fixed_vertex(CORNER_0, 32'h00010000));
        vertex_queue.push_back(fixed_vertex(CORNER_1, 32'h7fffffff));
        vertex_queue.push_back(fixed_vertex(CORNER_2, 32'h0));
        vertex_queue.push_back(fixed_vertex(CORNER_0, 32'hffff0000));
        vertex_queue.push_back(fixed_vertex(CORNER_1, 32'h80000000));
        vertex_queue.push_back(fixed_vertex(CORNER_2, 32'hffffffff));
        vertex_queue.push_back(fixed_vertex(CORNER_0, 32'h00020000));
        vertex_queue.push_back(fixed_vertex(CORNER_1, 32'hfffe0000));
        vertex_queue.push_back(fixed_vertex(CORNER_2, 32'hfffe0000));
        vertex_queue.push_back(fixed_vertex(CORNER_0, 32'h80000000));
        vertex_queue.push_back(fixed_vertex(CORNER_1, 32'h7fffffff));
        vertex_queue.push_back(fixed_vertex(CORNER_2, 32'h00050000));
        // broken sequences: index three, restart, stray corners
        vertex_queue.push_back(rand_vertex(2'd3));
        vertex_queue.push_back(rand_vertex(CORNER_2));
        vertex_queue.push_back(rand_vertex(CORNER_1));
        vertex_queue.push_back(rand_vertex(CORNER_0));
        vertex_queue.push_back(rand_vertex(CORNER_0));
        vertex_queue.push_back(rand_vertex(CORNER_1));
        vertex_queue.push_back(rand_vertex(CORNER_1));
        vertex_queue.push_back(rand_vertex(CORNER_2));
        drain();

        // random phases over several planes, extremes among them
        for (int ph = 0; ph < 6; ph++)
        begin
            feed_on = 1'b0;
            case (ph)
                0:
                begin
                    write_reg(CFG_NX, 32'h00010000);
                    write_reg(CFG_NY, 32'h0);
                    write_reg(CFG_NZ, 32'h0);
                    write_reg(CFG_OFS, 32'h0);
                end
                1:
                begin
                    write_reg(CFG_NX, 32'h7fffffff);
                    write_reg(CFG_NY, 32'h80000000);
                    write_reg(CFG_NZ, 32'h7fffffff);
                    write_reg(CFG_OFS, 32'h80000000);
                end
                2:
                begin
                    write_reg(CFG_OFS, 32'h7fffffff);
                    write_reg(CFG_NX, 32'h80000000);
                end
                default:
                begin
                    write_reg(CFG_NX, $urandom_range(0, 131072) - 65536);
                    write_reg(CFG_NY, $urandom_range(0, 131072) - 65536);
                    write_reg(CFG_NZ, $urandom);
                    write_reg(CFG_OFS, $urandom_range(0, 200000) - 100000);
                end
            endcase
            push_random(78);
            drain();
        end

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
sv/tpc_pkg.sv
sv/tpc_datapath.sv
sv/tpc_ctrl.sv
sv/triangle_plane_clipper.sv
bench/triangle_plane_clipper_test.sv
